[src/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg
// Types, token codes and keyword tables for the SQL token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } sts_in_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        overflow;
        logic        end_of_run;
    } sts_out_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_WORD   = 3'd1,
        MODE_DIGITS = 3'd2,
        MODE_QUOTED = 3'd3,
        MODE_ANGLE  = 3'd4
    } scan_mode_t;

    localparam logic [3:0] KIND_COMMA   = 4'd0;
    localparam logic [3:0] KIND_LPAREN  = 4'd1;
    localparam logic [3:0] KIND_RPAREN  = 4'd2;
    localparam logic [3:0] KIND_STAR    = 4'd3;
    localparam logic [3:0] KIND_DOT     = 4'd4;
    localparam logic [3:0] KIND_OPER    = 4'd5;
    localparam logic [3:0] KIND_STRING  = 4'd6;
    localparam logic [3:0] KIND_NUMBER  = 4'd7;
    localparam logic [3:0] KIND_IDENT   = 4'd8;
    localparam logic [3:0] KIND_KEYWORD = 4'd9;
    localparam logic [3:0] KIND_UNKNOWN = 4'd10;
    localparam logic [3:0] KIND_EOF     = 4'd11;

    localparam int KW_COUNT = 11;
    localparam int KW_CHARS = 6;

    typedef logic [KW_COUNT-1:0] kw_mask_t;

    // SELECT FROM WHERE ORDER BY LIMIT ASC DESC COUNT JOIN ON
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_CHARS] = '{
        '{"S", "E", "L", "E", "C", "T"},
        '{"F", "R", "O", "M", 8'h00, 8'h00},
        '{"W", "H", "E", "R", "E", 8'h00},
        '{"O", "R", "D", "E", "R", 8'h00},
        '{"B", "Y", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"L", "I", "M", "I", "T", 8'h00},
        '{"A", "S", "C", 8'h00, 8'h00, 8'h00},
        '{"D", "E", "S", "C", 8'h00, 8'h00},
        '{"C", "O", "U", "N", "T", 8'h00},
        '{"J", "O", "I", "N", 8'h00, 8'h00},
        '{"O", "N", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd4, 3'd5, 3'd5, 3'd2, 3'd5, 3'd3, 3'd4, 3'd5, 3'd4, 3'd2
    };

    function automatic logic [15:0] sat16(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

    // keywords whose character at position wl equals up
    function automatic kw_mask_t kw_keep(input logic [2:0] wl, input logic [7:0] up);
        kw_mask_t keep;
        keep = '0;
        if (wl < 3'd6) begin
            for (int k = 0; k < KW_COUNT; k++) begin
                if (KW_LEN[k] > wl && KW_TEXT[k][wl] == up) begin
                    keep[k] = 1'b1;
                end
            end
        end
        return keep;
    endfunction

    function automatic logic kw_hit(input kw_mask_t cand, input logic [2:0] wl);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (cand[k] && KW_LEN[k] == wl) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // token spanning from start up to (not including) end offset
    function automatic sts_out_t make_span(input logic [3:0] kind, input logic [15:0] start,
                                           input logic [16:0] stop);
        sts_out_t t;
        t = '0;
        t.token_kind  = kind;
        t.token_start = start;
        t.token_length = (stop >= {1'b0, start}) ? sat16(stop - {1'b0, start}) : 16'd0;
        return t;
    endfunction

endpackage

[src/sql_token_scanner.sv]
// ----------------------------------------------------------------------------
// sql_token_scanner
// Streaming SQL lexer: one source byte per transfer in, tokens out.
// ----------------------------------------------------------------------------
//  channel | ports                      | payload
//  --------+----------------------------+--------------------------------------
//  input   | s_valid s_ready s_data     | ch, last
//  result  | m_valid m_ready m_data     | kind, start, length, overflow, end_of_run
//
// A byte is decoded in the cycle it is taken; its zero to three tokens are
// loaded into a three-slot result register and leave one per cycle while m_ready is high.
// A byte yielding at most one token sustains one byte per cycle while m_ready is high;
// a byte with more tokens holds the input until its last token leaves the result port.
// s_ready is high when the result slots are empty or their last token leaves.
// Synchronous active-low reset clears the scan state and empties the result slots.
module sql_token_scanner #(
    parameter int MAX_SOURCE = 65536
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sts_pkg::sts_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sts_pkg::sts_out_t m_data
);
    import sts_pkg::*;

    localparam logic [16:0] LIMIT_POS = 17'(MAX_SOURCE > 65536 ? 65536 : MAX_SOURCE);

    scan_mode_t  mode_reg, mode_next;
    logic [16:0] pos_reg, pos_next;
    logic [15:0] ls_reg, ls_next;
    kw_mask_t    cand_reg, cand_next;
    logic [2:0]  wl_reg, wl_next;
    logic        ovf_reg, ovf_next;

    sts_out_t    slot_reg [3];
    sts_out_t    slot_next [3];
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  idx_reg, idx_next;

    logic        s_xfer, m_xfer, drain_last;

    // decode of the presented byte
    sts_out_t    cand_tok [4];
    logic [3:0]  cand_vld;
    logic [1:0]  n_tok;
    logic [16:0] p, nxt;
    logic [7:0]  c, up;
    logic        consumed;

    assign m_valid    = cnt_reg != 2'd0;
    assign drain_last = idx_reg == (cnt_reg - 2'd1);
    assign m_xfer     = m_valid && m_ready;
    assign s_ready    = !m_valid || (m_ready && drain_last);
    assign s_xfer     = s_valid && s_ready;

    always_comb begin
        m_data = slot_reg[idx_reg];
        m_data.end_of_run = drain_last;
    end

    always_comb begin
        c  = s_data.ch;
        up = (c >= "a" && c <= "z") ? c - 8'd32 : c;

        ovf_next  = ovf_reg;
        mode_next = mode_reg;
        ls_next   = ls_reg;
        cand_next = cand_reg;
        wl_next   = wl_reg;
        consumed  = 1'b0;
        cand_tok  = '{default: '0};
        cand_vld  = '0;

        if (pos_reg >= LIMIT_POS) begin
            ovf_next = 1'b1;
            p   = LIMIT_POS;
            nxt = LIMIT_POS;
        end else begin
            p   = pos_reg;
            nxt = pos_reg + 17'd1;
        end
        pos_next = nxt;

        // close or extend the lexeme in progress
        unique case (mode_reg)
            MODE_WORD: begin
                if (is_word(c)) begin
                    cand_next = cand_next & kw_keep(wl_next, up);
                    if (wl_next != 3'd7) wl_next = wl_next + 3'd1;
                    consumed = 1'b1;
                end else begin
                    cand_tok[0] = make_span(kw_hit(cand_reg, wl_reg) ? KIND_KEYWORD : KIND_IDENT,
                                            ls_reg, p);
                    cand_vld[0] = 1'b1;
                    mode_next   = MODE_IDLE;
                end
            end
            MODE_DIGITS: begin
                if (is_digit(c)) begin
                    consumed = 1'b1;
                end else begin
                    cand_tok[0] = make_span(KIND_NUMBER, ls_reg, p);
                    cand_vld[0] = 1'b1;
                    mode_next   = MODE_IDLE;
                end
            end
            MODE_QUOTED: begin
                consumed = 1'b1;
                if (c == "'") begin
                    cand_tok[0] = make_span(KIND_STRING, ls_reg, p);
                    cand_vld[0] = 1'b1;
                    mode_next   = MODE_IDLE;
                end
            end
            MODE_ANGLE: begin
                mode_next   = MODE_IDLE;
                cand_vld[0] = 1'b1;
                if (c == "=") begin
                    cand_tok[0] = make_span(KIND_OPER, ls_reg, nxt);
                    consumed    = 1'b1;
                end else begin
                    cand_tok[0] = make_span(KIND_OPER, ls_reg, p);
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase

        // start of a new lexeme
        if (!consumed && !is_blank(c)) begin
            ls_next = sat16(p);
            cand_tok[1].token_start  = sat16(p);
            cand_tok[1].token_length = 16'd1;
            if (c == ",") begin
                cand_tok[1].token_kind = KIND_COMMA;
                cand_vld[1] = 1'b1;
            end else if (c == "(") begin
                cand_tok[1].token_kind = KIND_LPAREN;
                cand_vld[1] = 1'b1;
            end else if (c == ")") begin
                cand_tok[1].token_kind = KIND_RPAREN;
                cand_vld[1] = 1'b1;
            end else if (c == "*") begin
                cand_tok[1].token_kind = KIND_STAR;
                cand_vld[1] = 1'b1;
            end else if (c == ".") begin
                cand_tok[1].token_kind = KIND_DOT;
                cand_vld[1] = 1'b1;
            end else if (c == "=") begin
                cand_tok[1].token_kind = KIND_OPER;
                cand_vld[1] = 1'b1;
            end else if (c == "<" || c == ">") begin
                mode_next = MODE_ANGLE;
            end else if (c == "'") begin
                ls_next   = sat16(nxt);
                mode_next = MODE_QUOTED;
            end else if (is_digit(c)) begin
                mode_next = MODE_DIGITS;
            end else if (is_alpha(c) || c == "_") begin
                cand_next = kw_keep(3'd0, up);
                wl_next   = 3'd1;
                mode_next = MODE_WORD;
            end else begin
                cand_tok[1].token_kind = KIND_UNKNOWN;
                cand_vld[1] = 1'b1;
            end
        end

        // end of text: flush the open lexeme, then eof, then back to reset state
        if (s_data.last) begin
            cand_vld[2] = mode_next != MODE_IDLE;
            unique case (mode_next)
                MODE_WORD:   cand_tok[2] = make_span(kw_hit(cand_next, wl_next) ?
                                                     KIND_KEYWORD : KIND_IDENT, ls_next, nxt);
                MODE_DIGITS: cand_tok[2] = make_span(KIND_NUMBER, ls_next, nxt);
                MODE_QUOTED: cand_tok[2] = make_span(KIND_STRING, ls_next, nxt);
                MODE_ANGLE:  cand_tok[2] = make_span(KIND_OPER, ls_next, nxt);
                default:     cand_tok[2] = '0;
            endcase
            cand_tok[3] = '0;
            cand_tok[3].token_kind  = KIND_EOF;
            cand_tok[3].token_start = sat16(nxt);
            cand_vld[3] = 1'b1;

            mode_next = MODE_IDLE;
            pos_next  = '0;
            ls_next   = '0;
            cand_next = '1;
            wl_next   = '0;
            ovf_next  = 1'b0;
        end

        // pack the live tokens into the result slots in order
        n_tok = 2'd0;
        slot_next = slot_reg;
        for (int i = 0; i < 4; i++) begin
            if (cand_vld[i] && n_tok != 2'd3) begin
                slot_next[n_tok] = cand_tok[i];
                slot_next[n_tok].overflow = ovf_next | (s_data.last & (pos_reg >= LIMIT_POS))
                                            | (s_data.last & ovf_reg);
                n_tok = n_tok + 2'd1;
            end
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (m_xfer) begin
            if (drain_last) begin
                cnt_next = 2'd0;
                idx_next = 2'd0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
        if (s_xfer) begin
            cnt_next = n_tok;
            idx_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            pos_reg  <= '0;
            ls_reg   <= '0;
            cand_reg <= '1;
            wl_reg   <= '0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= 2'd0;
            idx_reg  <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (s_xfer) begin
                mode_reg <= mode_next;
                pos_reg  <= pos_next;
                ls_reg   <= ls_next;
                cand_reg <= cand_next;
                wl_reg   <= wl_next;
                ovf_reg  <= ovf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            slot_reg <= slot_next;
        end
    end

endmodule

[src/sts_checker.sv]
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks on the SQL token scanner result channel.
// ----------------------------------------------------------------------------
module sts_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input sts_pkg::sts_out_t m_data
);
    import sts_pkg::*;

    // no result survives a reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_eof_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_kind == KIND_EOF |->
            m_data.token_length == 16'd0 && m_data.end_of_run)
        else $error("eof token malformed");

    a_single_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.token_kind == KIND_COMMA || m_data.token_kind == KIND_LPAREN ||
                    m_data.token_kind == KIND_RPAREN || m_data.token_kind == KIND_STAR ||
                    m_data.token_kind == KIND_DOT || m_data.token_kind == KIND_UNKNOWN)
        |-> m_data.token_length == 16'd1)
        else $error("single-byte token with wrong length");

    // input is taken only when no earlier token is stuck behind a stall
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid || m_ready)
        else $error("input transfer while results pending");

endmodule

bind sql_token_scanner sts_checker u_sts_checker (.*);
